@@ rtl/dct_pkg.sv @@
// Shared types, register offsets and the identification table of the down-counter timer.
package dct_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Register byte offsets.
    localparam logic [11:0] ADDR_CTRL     = 12'h000;
    localparam logic [11:0] ADDR_VALUE    = 12'h004;
    localparam logic [11:0] ADDR_RELOAD   = 12'h008;
    localparam logic [11:0] ADDR_INTSTAT  = 12'h00C;
    localparam logic [11:0] ADDR_ID_FIRST = 12'hFD0;
    localparam logic [11:0] ADDR_ID_LAST  = 12'hFFC;

    // Control register bit positions and width.
    localparam int CTRL_WIDTH     = 4;
    localparam int CTRL_ENABLE    = 0;
    localparam int CTRL_IRQ_EN    = 3;
    localparam int INTSTAT_CLEAR  = 0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] address;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } rsp_t;

    // Identification words, indexed by (offset - 0xFD0) / 4.
    function automatic logic [7:0] id_word(input logic [3:0] idx);
        logic [7:0] w;
        case (idx)
            4'd0:    w = 8'h04;
            4'd4:    w = 8'h22;
            4'd5:    w = 8'hb8;
            4'd6:    w = 8'h1b;
            4'd8:    w = 8'h0d;
            4'd9:    w = 8'hf0;
            4'd10:   w = 8'h05;
            4'd11:   w = 8'hb1;
            default: w = 8'h00;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/dct_if.sv @@
// Valid/ready channel interfaces for timer requests and results.
interface dct_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] address;
    logic [31:0] write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

interface dct_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq;

    modport source (output valid, output read_data, output irq, input ready);
    modport sink   (input valid, input read_data, input irq, output ready);
endinterface

@@ rtl/dct_in_stage.sv @@
// Input register that captures one request and holds it until the core consumes it.
module dct_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    dct_req_if.sink        req,
    input  logic           advance,
    output logic           valid,
    output dct_pkg::req_t  item
);

    logic          valid_reg;
    dct_pkg::req_t item_reg;

    // A new request enters when the stage is empty or drains this cycle.
    assign req.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.kind       <= req.kind;
            item_reg.address    <= req.address;
            item_reg.write_data <= req.write_data;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

@@ rtl/dct_core.sv @@
// Timer state registers with the tick, read and write update logic.
module dct_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  dct_pkg::req_t  item,
    output dct_pkg::rsp_t  result
);

    logic [dct_pkg::CTRL_WIDTH-1:0] ctrl_reg, ctrl_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic [COUNT_WIDTH-1:0]         reload_reg, reload_next;
    logic                           irq_reg, irq_next;
    logic [11:0]                    id_offset;
    logic                           id_hit;
    logic [31:0]                    read_data;

    assign id_offset = item.address - dct_pkg::ADDR_ID_FIRST;
    assign id_hit    = (item.address >= dct_pkg::ADDR_ID_FIRST) &&
                       (item.address <= dct_pkg::ADDR_ID_LAST);

    // Read mux; reads never change state.
    always_comb
    begin
        read_data = 32'd0;
        if (item.kind == dct_pkg::KIND_READ)
        begin
            if (id_hit)
            begin
                read_data = 32'(dct_pkg::id_word(id_offset[5:2]));
            end
            else
            begin
                unique case (item.address)
                    dct_pkg::ADDR_CTRL:    read_data = 32'(ctrl_reg);
                    dct_pkg::ADDR_VALUE:   read_data = 32'(count_reg);
                    dct_pkg::ADDR_RELOAD:  read_data = 32'(reload_reg);
                    dct_pkg::ADDR_INTSTAT: read_data = 32'(irq_reg);
                    default:               read_data = 32'd0;
                endcase
            end
        end
    end

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        count_next  = count_reg;
        reload_next = reload_reg;
        irq_next    = irq_reg;
        unique case (item.kind)
            dct_pkg::KIND_TICK:
            begin
                if (ctrl_reg[dct_pkg::CTRL_ENABLE])
                begin
                    // At zero the count reloads; a zero reload keeps it at zero.
                    if (count_reg == '0)
                    begin
                        count_next = reload_reg;
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_WIDTH'(1);
                        if ((count_reg == COUNT_WIDTH'(1)) && ctrl_reg[dct_pkg::CTRL_IRQ_EN])
                        begin
                            irq_next = 1'b1;
                        end
                    end
                end
            end
            dct_pkg::KIND_WRITE:
            begin
                unique case (item.address)
                    dct_pkg::ADDR_CTRL:
                        ctrl_next = item.write_data[dct_pkg::CTRL_WIDTH-1:0];
                    dct_pkg::ADDR_VALUE:
                        count_next = item.write_data[COUNT_WIDTH-1:0];
                    dct_pkg::ADDR_RELOAD:
                    begin
                        reload_next = item.write_data[COUNT_WIDTH-1:0];
                        count_next  = item.write_data[COUNT_WIDTH-1:0];
                    end
                    dct_pkg::ADDR_INTSTAT:
                    begin
                        if (item.write_data[dct_pkg::INTSTAT_CLEAR])
                        begin
                            irq_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            count_reg  <= '0;
            reload_reg <= '0;
            irq_reg    <= 1'b0;
        end
        else if (fire)
        begin
            ctrl_reg   <= ctrl_next;
            count_reg  <= count_next;
            reload_reg <= reload_next;
            irq_reg    <= irq_next;
        end
    end

    assign result.read_data = read_data;
    assign result.irq       = irq_next;

endmodule

@@ rtl/dct_out_stage.sv @@
// Result register that holds one response until the consumer takes it.
module dct_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  dct_pkg::rsp_t  rsp_in,
    output logic           can_load,
    dct_rsp_if.source      rsp
);

    logic          valid_reg;
    dct_pkg::rsp_t data_reg;

    // Space is available when empty or when the held result leaves this cycle.
    assign can_load = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rsp_in;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.read_data = data_reg.read_data;
    assign rsp.irq       = data_reg.irq;

endmodule

@@ rtl/apb_down_counter_timer.sv @@
// An accepted request is held in the input register, then its response in the output register.
// Throughput: one request per cycle while the consumer keeps taking responses.
// Requests keep flowing while a response waits, until both registers are full.
// Reset (rst_n low, asynchronous) clears control, count, reload and interrupt status
// and empties both pipeline registers.
module apb_down_counter_timer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    dct_req_if.sink    req,
    dct_rsp_if.source  rsp
);

    // The design is a two-register pipeline. The input stage captures a tick,
    // read or write request. The core then applies that request to the timer
    // state as it leaves the input stage: a tick decrements the count while enabled,
    // reloads it once it has rested at zero, and raises the interrupt status
    // on the step from one to zero when interrupts are enabled. Reads select
    // a register or an identification word, and writes update the register
    // at the addressed offset. The response, carrying read data and the
    // interrupt level after the request, lands in the output stage.

    logic          in_valid;
    dct_pkg::req_t in_item;
    logic          out_can_load;
    logic          advance;
    dct_pkg::rsp_t core_result;

    // The state is committed in the same cycle that the response is loaded,
    // so the order of requests and responses always matches.
    assign advance = in_valid && out_can_load;

    dct_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .valid   (in_valid),
        .item    (in_item)
    );

    dct_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item),
        .result (core_result)
    );

    dct_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .rsp_in   (core_result),
        .can_load (out_can_load),
        .rsp      (rsp)
    );

endmodule
